[rtl/assert_macros.svh]
// assertion macros shared by the duty profile modulator rtl
// expects clk_i and rst_ni in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define DPBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define DPBP_ASSERT_IMPL(lbl, ante, cons, msg) \
  `DPBP_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define DPBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  `DPBP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[rtl/dpbp_pkg.sv]
// shared types, constants and helper functions of the duty profile modulator
// no dependencies; used by every module in rtl
`default_nettype none

package dpbp_pkg;

  localparam int unsigned SLOT_W  = 7;
  localparam int unsigned STEP_W  = 5;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned ERR_W   = 9;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  localparam int unsigned SLOTS_PER_PERIOD = 100;
  localparam int unsigned COSINE_STEPS     = 10;
  localparam int unsigned SAW_STEPS        = 30;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS_PER_PERIOD - 1);
  localparam logic [STEP_W:0]   COS_STEPS_C = (STEP_W+1)'(COSINE_STEPS);
  localparam logic [STEP_W:0]   SAW_STEPS_C = (STEP_W+1)'(SAW_STEPS);

  localparam logic [PCT_W-1:0] PCT_MAX      = PCT_W'(100);
  localparam logic [PCT_W-1:0] PEAK_RESET   = PCT_W'(82);

  // cosine coefficients, unsigned q1.24
  localparam int unsigned COS_FRAC   = 24;
  localparam int unsigned COS_COEF_W = 25;
  localparam int unsigned PROD_W     = COS_COEF_W + PCT_W;
  localparam logic [PROD_W:0] Q24_HALF = (PROD_W+1)'(2**(COS_FRAC-1));

  // floor(x / SAW_STEPS) as (x * SAW_RECIP) >> SAW_SHIFT, exact for x below 2^SAW_X_W
  localparam int unsigned SAW_X_W    = 13;
  localparam int unsigned SAW_SHIFT  = 20;
  localparam int unsigned SAW_RECIP_W = 16;
  localparam int unsigned SAW_PROD_W = SAW_X_W + SAW_RECIP_W;
  localparam logic [SAW_RECIP_W-1:0] SAW_RECIP =
    SAW_RECIP_W'((2**SAW_SHIFT + SAW_STEPS - 1) / SAW_STEPS);

  // profile modes; the unused code behaves as fixed
  localparam logic [MODE_W-1:0] MODE_FIXED    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COSINE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SAWTOOTH = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROFILE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_PERCENT = 2'd1;

  typedef enum logic {
    KIND_REPORT,
    KIND_SLOT
  } kind_e;

  // slot engine to profile unit
  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic              slot_zero;
  } prof_req_t;

  // profile unit to slot engine
  typedef struct packed {
    logic              ready;
    logic [PCT_W-1:0]  pct;
    logic [STEP_W-1:0] nstep;
  } prof_rsp_t;

  function automatic logic [STEP_W-1:0] step_advance(input logic [STEP_W-1:0] step,
                                                     input logic [MODE_W-1:0] mode);
    logic [STEP_W:0]   nxt;
    logic [STEP_W-1:0] res;
    nxt = {1'b0, step} + 1'b1;
    case (mode)
      MODE_COSINE:   res = (nxt >= COS_STEPS_C) ? '0 : nxt[STEP_W-1:0];
      MODE_SAWTOOTH: res = (nxt > SAW_STEPS_C) ? '0 : nxt[STEP_W-1:0];
      default:       res = '0;
    endcase
    return res;
  endfunction

  // step in range of the mode, otherwise restart at zero
  function automatic logic [STEP_W-1:0] step_normalize(input logic [STEP_W-1:0] step,
                                                       input logic [MODE_W-1:0] mode);
    logic [STEP_W-1:0] res;
    case (mode)
      MODE_COSINE:   res = ({1'b0, step} >= COS_STEPS_C) ? '0 : step;
      MODE_SAWTOOTH: res = ({1'b0, step} > SAW_STEPS_C) ? '0 : step;
      default:       res = '0;
    endcase
    return res;
  endfunction

  function automatic logic [COS_COEF_W-1:0] cos_coef(input logic [3:0] idx);
    logic [COS_COEF_W-1:0] c;
    case (idx)
      4'd0:    c = 25'd16777216;
      4'd1:    c = 25'd15175137;
      4'd2:    c = 25'd10980839;
      4'd3:    c = 25'd5796398;
      4'd4:    c = 25'd1602092;
      4'd5:    c = 25'd0;
      4'd6:    c = 25'd1602066;
      4'd7:    c = 25'd5796356;
      4'd8:    c = 25'd10980797;
      4'd9:    c = 25'd15175111;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/duty_profile_bresenham_pwm.sv]
// duty_profile_bresenham_pwm: spreads the busy slots of each 100-slot period evenly
// with a bresenham accumulator, the period percentage taken from a fixed, cosine
// or sawtooth profile.
// input side: tick_i is taken as a transfer when push is high and full is low;
//   a tick of 1 advances one slot, a tick of 0 only reports the current state.
// result side: while empty is low the oldest result sits on the result ports and
//   leaves on a transfer with pop high. every input item gives one result.
// config: cfg_valid_i with cfg_index_i (0 profile_mode, 1 peak_percent), cfg_data_i;
//   cfg_ready_o is always high. write only while the block is idle; the block does
//   not enforce it. writes apply from the next period start; peaks over 100 saturate.
// path: an input item passes the front register, the queue and the result
//   register before its result is shown. throughput: one item per cycle while the
//   receiver pops; a period start waits for the two-stage percentage unit to
//   settle on the current registers, which only stalls after reset or a write.
// reset: counters and percentage cleared, mode fixed, peak 82, queues emptied.
// a stalled receiver fills the result register, then the queue, then raises full.
`default_nettype none

module duty_profile_bresenham_pwm #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                push,
  output logic                               full,
  input  wire                                tick_i,
  output logic                               empty,
  input  wire                                pop,
  output logic                               busy_slot_o,
  output logic [dpbp_pkg::PCT_W-1:0]         period_percent_o,
  output logic [dpbp_pkg::SLOT_W-1:0]        slot_number_o,
  output logic [dpbp_pkg::STEP_W-1:0]        profile_index_o,
  output logic                               period_done_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire [dpbp_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire [dpbp_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [dpbp_pkg::MODE_W-1:0] mode_q;
  logic [dpbp_pkg::PCT_W-1:0]  peak_q;

  logic                f_valid, f_ready, b_valid, b_ready;
  dpbp_pkg::kind_e     f_kind, b_kind;
  dpbp_pkg::prof_req_t prof_req;
  dpbp_pkg::prof_rsp_t prof_rsp;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= dpbp_pkg::MODE_FIXED;
      peak_q <= dpbp_pkg::PEAK_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dpbp_pkg::REG_PROFILE_MODE: mode_q <= cfg_data_i[dpbp_pkg::MODE_W-1:0];
        dpbp_pkg::REG_PEAK_PERCENT:
          peak_q <= (cfg_data_i > dpbp_pkg::PCT_MAX) ? dpbp_pkg::PCT_MAX : cfg_data_i;
        default: ;
      endcase
    end
  end

  dpbp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .tick_i    (tick_i),
    .q_valid_o (f_valid),
    .q_ready_i (f_ready),
    .q_kind_o  (f_kind)
  );

  dpbp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_kind_i  (f_kind),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_kind_o  (b_kind)
  );

  dpbp_profile u_profile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mode_i (mode_q),
    .peak_i (peak_q),
    .req_i  (prof_req),
    .rsp_o  (prof_rsp)
  );

  dpbp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mode_i           (mode_q),
    .q_valid_i        (b_valid),
    .q_ready_o        (b_ready),
    .q_kind_i         (b_kind),
    .prof_req_o       (prof_req),
    .prof_rsp_i       (prof_rsp),
    .empty            (empty),
    .pop              (pop),
    .busy_slot_o      (busy_slot_o),
    .period_percent_o (period_percent_o),
    .slot_number_o    (slot_number_o),
    .profile_index_o  (profile_index_o),
    .period_done_o    (period_done_o)
  );

endmodule

`default_nettype wire

[rtl/dpbp_front.sv]
// front stage: takes tick items from the push side and tags them by kind
// depends on dpbp_pkg
`default_nettype none

module dpbp_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push,
  output logic                full,
  input  wire                 tick_i,
  output logic                q_valid_o,
  input  wire                 q_ready_i,
  output dpbp_pkg::kind_e     q_kind_o
);

  logic            v_q, v_d;
  dpbp_pkg::kind_e kind_q;
  logic            accept;

  assign full      = v_q && !q_ready_i;
  assign accept    = push && !full;
  assign v_d       = accept || (v_q && !q_ready_i);
  assign q_valid_o = v_q;
  assign q_kind_o  = kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= tick_i ? dpbp_pkg::KIND_SLOT : dpbp_pkg::KIND_REPORT;
    end
  end

endmodule

`default_nettype wire

[rtl/dpbp_fifo.sv]
// short queue of classified items between the front stage and the slot engine
// depends on dpbp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module dpbp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              wr_valid_i,
  output logic             wr_ready_o,
  input  dpbp_pkg::kind_e  wr_kind_i,
  output logic             rd_valid_o,
  input  wire              rd_ready_i,
  output dpbp_pkg::kind_e  rd_kind_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  dpbp_pkg::kind_e mem [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q;
  logic          do_wr, do_rd;

  assign wr_ready_o = (cnt_q != CNT_FULL);
  assign rd_valid_o = (cnt_q != '0);
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;
  assign rd_kind_o  = mem[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_ptr_q] <= wr_kind_i;
    end
  end

  `DPBP_ASSERT(a_fifo_cnt_bound, cnt_q <= CNT_FULL, "queue count beyond depth")
  `DPBP_ASSERT_NEXT(a_fifo_fill, do_wr && !do_rd, cnt_q == $past(cnt_q) + 1'b1, "queue fill lost")

endmodule

`default_nettype wire

[rtl/dpbp_profile.sv]
// two-stage unit that works out the busy percentage of the coming period
// depends on dpbp_pkg
`default_nettype none

module dpbp_profile (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire [dpbp_pkg::MODE_W-1:0]           mode_i,
  input  wire [dpbp_pkg::PCT_W-1:0]            peak_i,
  input  dpbp_pkg::prof_req_t                  req_i,
  output dpbp_pkg::prof_rsp_t                  rsp_o
);

  localparam int unsigned TAG_W = dpbp_pkg::STEP_W + dpbp_pkg::MODE_W + dpbp_pkg::PCT_W;

  logic [dpbp_pkg::STEP_W-1:0]      sel_step, nstep;
  logic [TAG_W-1:0]                 tag;
  logic [dpbp_pkg::COS_COEF_W-1:0]  mul_a;
  logic [dpbp_pkg::PROD_W-1:0]      prod_d;

  // stage 1
  logic                             s1_v_q;
  logic [TAG_W-1:0]                 s1_tag_q;
  logic [dpbp_pkg::STEP_W-1:0]      s1_nstep_q;
  logic [dpbp_pkg::MODE_W-1:0]      s1_mode_q;
  logic [dpbp_pkg::PCT_W-1:0]       s1_peak_q;
  logic [dpbp_pkg::PROD_W-1:0]      s1_prod_q;

  // stage 2
  logic [dpbp_pkg::PROD_W:0]        rnd;
  logic [dpbp_pkg::SAW_PROD_W-1:0]  saw_prod;
  logic [dpbp_pkg::PCT_W-1:0]       raw_pct, pct_d;
  logic                             s2_v_q;
  logic [TAG_W-1:0]                 s2_tag_q;
  logic [dpbp_pkg::PCT_W-1:0]       s2_pct_q;
  logic [dpbp_pkg::STEP_W-1:0]      s2_nstep_q;

  // mid-period the step of the next period is the advanced one
  always_comb begin
    sel_step = req_i.slot_zero ? req_i.step : dpbp_pkg::step_advance(req_i.step, mode_i);
    nstep    = dpbp_pkg::step_normalize(sel_step, mode_i);
    tag      = {sel_step, mode_i, peak_i};
    mul_a    = (mode_i == dpbp_pkg::MODE_COSINE) ?
               dpbp_pkg::cos_coef(nstep[3:0]) : dpbp_pkg::COS_COEF_W'(nstep);
    prod_d   = dpbp_pkg::PROD_W'(mul_a) * dpbp_pkg::PROD_W'(peak_i);
  end

  always_comb begin
    rnd      = {1'b0, s1_prod_q} + dpbp_pkg::Q24_HALF;
    saw_prod = dpbp_pkg::SAW_PROD_W'(s1_prod_q[dpbp_pkg::SAW_X_W-1:0]) *
               dpbp_pkg::SAW_PROD_W'(dpbp_pkg::SAW_RECIP);
    case (s1_mode_q)
      dpbp_pkg::MODE_COSINE:
        raw_pct = rnd[dpbp_pkg::COS_FRAC+dpbp_pkg::PCT_W-1:dpbp_pkg::COS_FRAC];
      dpbp_pkg::MODE_SAWTOOTH:
        raw_pct = saw_prod[dpbp_pkg::SAW_SHIFT+dpbp_pkg::PCT_W-1:dpbp_pkg::SAW_SHIFT];
      default:
        raw_pct = s1_peak_q;
    endcase
    pct_d = (raw_pct > dpbp_pkg::PCT_MAX) ? dpbp_pkg::PCT_MAX : raw_pct;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= 1'b1;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q   <= tag;
    s1_nstep_q <= nstep;
    s1_mode_q  <= mode_i;
    s1_peak_q  <= peak_i;
    s1_prod_q  <= prod_d;
    s2_tag_q   <= s1_tag_q;
    s2_pct_q   <= pct_d;
    s2_nstep_q <= s1_nstep_q;
  end

  // result only counts once it was worked out from the inputs now in force
  assign rsp_o.ready = s2_v_q && (s2_tag_q == tag);
  assign rsp_o.pct   = s2_pct_q;
  assign rsp_o.nstep = s2_nstep_q;

endmodule

`default_nettype wire

[rtl/dpbp_back.sv]
// slot engine: bresenham error accumulator, slot and step counters, result register
// depends on dpbp_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module dpbp_back (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire [dpbp_pkg::MODE_W-1:0]       mode_i,
  input  wire                              q_valid_i,
  output logic                             q_ready_o,
  input  dpbp_pkg::kind_e                  q_kind_i,
  output dpbp_pkg::prof_req_t              prof_req_o,
  input  dpbp_pkg::prof_rsp_t              prof_rsp_i,
  output logic                             empty,
  input  wire                              pop,
  output logic                             busy_slot_o,
  output logic [dpbp_pkg::PCT_W-1:0]       period_percent_o,
  output logic [dpbp_pkg::SLOT_W-1:0]      slot_number_o,
  output logic [dpbp_pkg::STEP_W-1:0]      profile_index_o,
  output logic                             period_done_o
);

  logic [dpbp_pkg::SLOT_W-1:0]   slot_q;
  logic [dpbp_pkg::STEP_W-1:0]   step_q, step_eff, step_nxt;
  logic [dpbp_pkg::PCT_W-1:0]    cur_q, pct_eff;
  logic signed [dpbp_pkg::ERR_W-1:0] err_q;
  logic signed [dpbp_pkg::ERR_W:0]   two_p, err_base, delta, err_sum;
  logic                          slot_zero, is_slot, busy, done, out_free, take, adv;

  logic                          out_v_q;
  logic                          out_busy_q, out_done_q;
  logic [dpbp_pkg::PCT_W-1:0]    out_pct_q;
  logic [dpbp_pkg::SLOT_W-1:0]   out_slot_q;
  logic [dpbp_pkg::STEP_W-1:0]   out_step_q;

  assign slot_zero = (slot_q == '0);
  assign is_slot   = (q_kind_i == dpbp_pkg::KIND_SLOT);
  assign out_free  = !out_v_q || pop;
  // a period start waits for its percentage
  assign take      = q_valid_i && out_free && (!is_slot || !slot_zero || prof_rsp_i.ready);
  assign adv       = take && is_slot;
  assign q_ready_o = out_free && (!is_slot || !slot_zero || prof_rsp_i.ready);

  assign prof_req_o.step      = step_q;
  assign prof_req_o.slot_zero = slot_zero;

  always_comb begin
    pct_eff  = slot_zero ? prof_rsp_i.pct : cur_q;
    step_eff = slot_zero ? prof_rsp_i.nstep : step_q;
    two_p    = signed'({2'b00, pct_eff, 1'b0});
    err_base = slot_zero ? (two_p - 10'sd100) : {err_q[dpbp_pkg::ERR_W-1], err_q};
    busy     = (err_base > 10'sd0);
    delta    = busy ? (two_p - 10'sd200) : two_p;
    err_sum  = err_base + delta;
    done     = (slot_q == dpbp_pkg::SLOT_LAST);
    step_nxt = done ? dpbp_pkg::step_advance(step_eff, mode_i) : step_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      step_q  <= '0;
      cur_q   <= '0;
      err_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (adv) begin
        slot_q <= done ? '0 : slot_q + 1'b1;
        step_q <= step_nxt;
        cur_q  <= pct_eff;
        err_q  <= signed'(err_sum[dpbp_pkg::ERR_W-1:0]);
      end
      out_v_q <= take || (out_v_q && !pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (is_slot) begin
        out_busy_q <= busy;
        out_pct_q  <= pct_eff;
        out_step_q <= step_eff;
        out_done_q <= done;
      end else begin
        out_busy_q <= 1'b0;
        out_pct_q  <= cur_q;
        out_step_q <= step_q;
        out_done_q <= 1'b0;
      end
      out_slot_q <= slot_q;
    end
  end

  assign empty            = !out_v_q;
  assign busy_slot_o      = out_busy_q;
  assign period_percent_o = out_pct_q;
  assign slot_number_o    = out_slot_q;
  assign profile_index_o  = out_step_q;
  assign period_done_o    = out_done_q;

  `DPBP_ASSERT(a_slot_range, slot_q <= dpbp_pkg::SLOT_LAST, "slot counter out of range")
  `DPBP_ASSERT(a_err_range, (err_q > -9'sd200) && (err_q <= 9'sd200), "error accumulator drift")
  `DPBP_ASSERT_NEXT(a_period_wrap, adv && done, slot_q == '0, "period did not wrap")

endmodule

`default_nettype wire
